[sv/fragment_reassembly_tracker_assert.svh]
// assertion macros shared by the tracker modules
// each macro expects clk and rst_n in scope
`ifndef FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock outside reset
`define FRT_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle
`define FRT_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// consequence holds in the following cycle
`define FRT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define FRT_ASSERT_HOLD(lbl, cond, msg)
`define FRT_ASSERT_IMPL(lbl, pre, post, msg)
`define FRT_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[sv/frt_pkg.sv]
package frt_pkg;

  // fixed field widths
  localparam int CFG_W      = 5;
  localparam int TOTAL_W    = 7;
  localparam int CIDX_W     = 6;
  localparam int NONCE_IN_W = 32;
  localparam int SLOT_W     = 4;

  localparam logic [CFG_W-1:0] ACTIVE_SETS_RESET = 5'd16;

  // result outcome codes
  typedef enum logic [2:0] {
    OUT_ADDED   = 3'd0,
    OUT_DUP     = 3'd1,
    OUT_NEW     = 3'd2,
    OUT_EVICT   = 3'd3,
    OUT_TOO_BIG = 3'd4
  } outcome_t;

  // one chunk header
  typedef struct packed {
    logic [31:0]           sender_host;
    logic [15:0]           sender_port;
    logic [NONCE_IN_W-1:0] msg_nonce;
    logic [TOTAL_W-1:0]    chunk_total;
    logic [CIDX_W-1:0]     chunk_index;
  } frt_in_t;

  // one result
  typedef struct packed {
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot;
    logic              packet_complete;
  } frt_out_t;

  // control from the handshake logic to the table
  typedef struct packed {
    logic             fire;
    logic [CFG_W-1:0] active_sets;
  } frt_ctrl_t;

endpackage

[sv/frt_table.sv]
`include "fragment_reassembly_tracker_assert.svh"

module frt_table
  import frt_pkg::*;
#(
  parameter int SET_SLOTS   = 16,
  parameter int MAX_CHUNKS  = 64,
  parameter int NONCE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  frt_ctrl_t ctrl,
  input  frt_in_t   item,
  output frt_out_t  result
);

  localparam int IDX_W     = (SET_SLOTS > 1) ? $clog2(SET_SLOTS) : 1;
  localparam int CNT_W_RAW = $clog2(SET_SLOTS + 1);
  localparam int CNT_W     = (CNT_W_RAW > CFG_W) ? CNT_W_RAW : CFG_W;
  localparam int NW        = (NONCE_WIDTH < NONCE_IN_W) ? NONCE_WIDTH : NONCE_IN_W;
  localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_CHUNKS);
  localparam logic [CNT_W-1:0]   SLOTS_CNT = CNT_W'(SET_SLOTS);

  // entry storage, one lane per slot
  logic [SET_SLOTS-1:0]  valid_r;
  logic [CNT_W-1:0]      fill_r;
  logic [31:0]           host_r  [SET_SLOTS];
  logic [15:0]           port_r  [SET_SLOTS];
  logic [NW-1:0]         nonce_r [SET_SLOTS];
  logic [TOTAL_W-1:0]    total_r [SET_SLOTS];
  logic [MAX_CHUNKS-1:0] seen_r  [SET_SLOTS];
  logic [IDX_W-1:0]      rank_r  [SET_SLOTS];

  logic [CNT_W-1:0]      cap;
  logic                  too_big;
  logic                  idx_ok;
  logic [MAX_CHUNKS-1:0] chunk_bit;
  logic [MAX_CHUNKS-1:0] full_mask;
  logic [SET_SLOTS-1:0]  match;
  logic [SET_SLOTS-1:0]  hit_oh;
  logic [SET_SLOTS-1:0]  oldest_oh;
  logic [SET_SLOTS-1:0]  free_oh;
  logic [SET_SLOTS-1:0]  tgt_oh;
  logic [SET_SLOTS-1:0]  free_vec;
  logic                  hit_any;
  logic                  evict;
  logic                  hit_dup;
  logic                  hit_done;
  logic                  new_done;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      tgt_idx;
  logic [IDX_W+SLOT_W-1:0] slot_wide;
  logic                  wr_hit;
  logic                  wr_new;

  // clamp the configured capacity
  always_comb begin
    if (ctrl.active_sets == '0) begin
      cap = CNT_W'(1);
    end else if (CNT_W'(ctrl.active_sets) > SLOTS_CNT) begin
      cap = SLOTS_CNT;
    end else begin
      cap = CNT_W'(ctrl.active_sets);
    end
  end

  // chunk bit and completion mask
  assign too_big = item.chunk_total > MAX_TOTAL;
  assign idx_ok  = TOTAL_W'(item.chunk_index) < item.chunk_total;

  always_comb begin
    for (int k = 0; k < MAX_CHUNKS; k++) begin
      chunk_bit[k] = idx_ok && (item.chunk_index == CIDX_W'(k));
      full_mask[k] = TOTAL_W'(k) < item.chunk_total;
    end
  end

  // key compare in every lane
  always_comb begin
    for (int i = 0; i < SET_SLOTS; i++) begin
      match[i] = valid_r[i] && (host_r[i] == item.sender_host) &&
                 (port_r[i] == item.sender_port) &&
                 (nonce_r[i] == item.msg_nonce[NW-1:0]) &&
                 (total_r[i] == item.chunk_total) && idx_ok;
    end
  end

  // newest match and oldest valid entry by pairwise rank compare
  always_comb begin
    for (int i = 0; i < SET_SLOTS; i++) begin
      hit_oh[i]    = match[i];
      oldest_oh[i] = valid_r[i];
      for (int j = 0; j < SET_SLOTS; j++) begin
        if (j != i) begin
          if (match[j] && (rank_r[j] < rank_r[i])) begin
            hit_oh[i] = 1'b0;
          end
          if (valid_r[j] && (rank_r[j] > rank_r[i])) begin
            oldest_oh[i] = 1'b0;
          end
        end
      end
    end
  end

  // lowest free slot
  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + 1'b1);

  assign hit_any = |hit_oh;
  assign evict   = !hit_any && (fill_r >= cap);
  assign tgt_oh  = evict ? oldest_oh : free_oh;

  // gather the selected lane
  always_comb begin
    hit_dup  = 1'b0;
    hit_done = 1'b0;
    hit_idx  = '0;
    tgt_idx  = '0;
    for (int i = 0; i < SET_SLOTS; i++) begin
      if (hit_oh[i]) begin
        hit_dup  = hit_dup | (|(seen_r[i] & chunk_bit));
        hit_done = hit_done | ((seen_r[i] | chunk_bit) == full_mask);
        hit_idx  = hit_idx | IDX_W'(i);
      end
      if (tgt_oh[i]) begin
        tgt_idx = tgt_idx | IDX_W'(i);
      end
    end
  end

  assign new_done = chunk_bit == full_mask;

  // result for the item at the table input
  always_comb begin
    slot_wide = {{SLOT_W{1'b0}}, (hit_any ? hit_idx : tgt_idx)};
    if (too_big) begin
      result.outcome         = OUT_TOO_BIG;
      result.slot            = '0;
      result.packet_complete = 1'b0;
    end else if (hit_any) begin
      result.outcome         = hit_dup ? OUT_DUP : OUT_ADDED;
      result.slot            = slot_wide[SLOT_W-1:0];
      result.packet_complete = hit_done;
    end else begin
      result.outcome         = evict ? OUT_EVICT : OUT_NEW;
      result.slot            = slot_wide[SLOT_W-1:0];
      result.packet_complete = new_done;
    end
  end

  assign wr_hit = ctrl.fire && !too_big && hit_any;
  assign wr_new = ctrl.fire && !too_big && !hit_any;

  // valid bits and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
    end else if (wr_new) begin
      valid_r <= valid_r | tgt_oh;
      if (!evict) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // entry payload and age ranks
  always_ff @(posedge clk) begin
    for (int i = 0; i < SET_SLOTS; i++) begin
      if (wr_hit && hit_oh[i]) begin
        seen_r[i] <= seen_r[i] | chunk_bit;
      end
      if (wr_new) begin
        if (tgt_oh[i]) begin
          host_r[i]  <= item.sender_host;
          port_r[i]  <= item.sender_port;
          nonce_r[i] <= item.msg_nonce[NW-1:0];
          total_r[i] <= item.chunk_total;
          seen_r[i]  <= chunk_bit;
          rank_r[i]  <= '0;
        end else if (valid_r[i]) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
    end
  end

  // checks
  `FRT_ASSERT_HOLD(a_fill_tracks_valid, $countones(valid_r) == fill_r, "fill count off")
  `FRT_ASSERT_NEXT(a_new_grows, wr_new && !evict, fill_r == $past(fill_r) + 1'b1, "no growth")
  `FRT_ASSERT_IMPL(a_evict_full, wr_new && evict, $onehot(tgt_oh) && fill_r != '0, "bad evict")

endmodule

[sv/fragment_reassembly_tracker.sv]
// channel | ports                          | accepted when
// input   | in_valid, in_ready, in_data    | in_valid && in_ready at rising clk
// result  | out_valid, out_ready, out_data | out_valid && out_ready at rising clk
// config  | cfg_wr_en, cfg_wr_data         | cfg_wr_en at rising clk
//
// one item per cycle sustained while out_ready stays high; an item is held in the
// input register once accepted and reaches out_data through the result register,
// the table lookup and update done between them by a parallel compare across all slots.
// synchronous active-low reset clears the valid bits, fill count and handshake
// state; active_sets returns to 16. no clearing pass is needed.
// a stalled result holds the table stage; input stays ready while that stage
// can move on.
`include "fragment_reassembly_tracker_assert.svh"

module fragment_reassembly_tracker
  import frt_pkg::*;
#(
  parameter int SET_SLOTS   = 16,
  parameter int MAX_CHUNKS  = 64,
  parameter int NONCE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  frt_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output frt_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  logic             s1_valid_r, s1_valid_nxt;
  frt_in_t          s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  frt_out_t         out_data_r;
  logic [CFG_W-1:0] active_sets_r;
  logic             advance;
  logic             in_fire;
  frt_ctrl_t        ctrl;
  frt_out_t         tbl_result;

  // stage handshake
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      active_sets_r <= ACTIVE_SETS_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        active_sets_r <= cfg_wr_data;
      end
    end
  end

  // input and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= tbl_result;
    end
  end

  assign ctrl.fire        = advance;
  assign ctrl.active_sets = active_sets_r;

  // lookup table
  frt_table #(
    .SET_SLOTS   (SET_SLOTS),
    .MAX_CHUNKS  (MAX_CHUNKS),
    .NONCE_WIDTH (NONCE_WIDTH)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .item   (s1_item_r),
    .result (tbl_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `FRT_ASSERT_NEXT(a_adv_fills_out, advance, out_valid_r, "result lost")
  `FRT_ASSERT_NEXT(a_s1_holds, s1_valid_r && !advance, s1_valid_r && $stable(s1_item_r), "s1 moved")
  `FRT_ASSERT_IMPL(a_drop_clean, out_valid_r && out_data_r.outcome == OUT_TOO_BIG, out_data_r.slot == '0 && !out_data_r.packet_complete, "drop fields")

endmodule

[sim/fragment_reassembly_tracker_checker.sv]
`timescale 1ns / 100ps

module fragment_reassembly_tracker_checker
  import frt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  frt_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  frt_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output int               error_count,
  output int               outstanding,
  output int               result_count,
  output int               eviction_count,
  output int               complete_count
);

  localparam int TABLE_SLOTS = 16;
  localparam int CHUNK_LIMIT = 64;

  // shadow copy of the tracking table
  logic [CFG_W-1:0] table_size;
  logic             ent_valid [TABLE_SLOTS];
  logic [31:0]      ent_host  [TABLE_SLOTS];
  logic [15:0]      ent_port  [TABLE_SLOTS];
  logic [31:0]      ent_nonce [TABLE_SLOTS];
  logic [6:0]       ent_total [TABLE_SLOTS];
  logic [63:0]      ent_seen  [TABLE_SLOTS];
  int               ent_age   [TABLE_SLOTS];
  int               fill;

  frt_out_t expected_results [$];
  int       errs      = 0;
  int       results   = 0;
  int       evicts    = 0;
  int       completes = 0;

  // applies one chunk header to the shadow table and returns the result it should give
  function automatic frt_out_t predict_chunk(frt_in_t hdr);
    frt_out_t    res;
    int          cap;
    int          hit;
    int          tgt;
    logic [63:0] chunk_mask;
    logic [63:0] all_mask;
    res = '0;
    if (hdr.chunk_total > CHUNK_LIMIT) begin
      res.outcome = OUT_TOO_BIG;
      return res;
    end
    cap = (table_size == 0) ? 1 : ((table_size > TABLE_SLOTS) ? TABLE_SLOTS : int'(table_size));

    // newest matching entry wins
    hit = -1;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (ent_valid[i] && ent_host[i] == hdr.sender_host && ent_port[i] == hdr.sender_port &&
          ent_nonce[i] == hdr.msg_nonce && ent_total[i] == hdr.chunk_total &&
          hdr.chunk_index < hdr.chunk_total) begin
        if (hit < 0 || ent_age[i] < ent_age[hit])
          hit = i;
      end
    end

    if (hit >= 0) begin
      chunk_mask = 64'd1 << hdr.chunk_index;
      res.outcome = ((ent_seen[hit] & chunk_mask) != 0) ? OUT_DUP : OUT_ADDED;
      ent_seen[hit] = ent_seen[hit] | chunk_mask;
      tgt = hit;
    end else begin
      // full table: evict the oldest-created entry
      tgt = -1;
      res.outcome = OUT_NEW;
      if (fill >= cap) begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (ent_valid[i] && (tgt < 0 || ent_age[i] > ent_age[tgt]))
            tgt = i;
        if (tgt >= 0)
          res.outcome = OUT_EVICT;
      end
      // otherwise the lowest free slot
      if (tgt < 0) begin
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
          if (!ent_valid[i])
            tgt = i;
      end
      if (ent_valid[tgt]) begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (ent_valid[i] && i != tgt && ent_age[i] < ent_age[tgt])
            ent_age[i]++;
      end else begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (ent_valid[i])
            ent_age[i]++;
        fill++;
      end
      ent_valid[tgt] = 1'b1;
      ent_host[tgt]  = hdr.sender_host;
      ent_port[tgt]  = hdr.sender_port;
      ent_nonce[tgt] = hdr.msg_nonce;
      ent_total[tgt] = hdr.chunk_total;
      ent_seen[tgt]  = (hdr.chunk_index < hdr.chunk_total) ? (64'd1 << hdr.chunk_index) : 64'd0;
      ent_age[tgt]   = 0;
    end

    all_mask = (ent_total[tgt] >= 64) ? '1 : ((64'd1 << ent_total[tgt]) - 64'd1);
    res.slot = tgt[SLOT_W-1:0];
    res.packet_complete = ((ent_seen[tgt] & all_mask) == all_mask);
    return res;
  endfunction

  // watch the channels, predict on input items, compare on result items
  always @(posedge clk) begin
    frt_out_t want;
    if (!rst_n) begin
      table_size = ACTIVE_SETS_RESET;
      fill = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        ent_valid[i] = 1'b0;
        ent_age[i]   = 0;
      end
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result item: outcome %0d slot %0d complete %0d",
                     out_data.outcome, out_data.slot, out_data.packet_complete);
        end else begin
          want = expected_results.pop_front();
          results++;
          if (out_data.outcome !== want.outcome || out_data.slot !== want.slot ||
              out_data.packet_complete !== want.packet_complete) begin
            errs++;
            if (errs <= 10)
              $display("result %0d mismatch: expected outcome %0d slot %0d complete %0d, got outcome %0d slot %0d complete %0d",
                       results, want.outcome, want.slot, want.packet_complete,
                       out_data.outcome, out_data.slot, out_data.packet_complete);
          end
        end
      end
      if (cfg_wr_en)
        table_size = cfg_wr_data;
      if (in_valid && in_ready) begin
        want = predict_chunk(in_data);
        if (want.outcome == OUT_EVICT)
          evicts++;
        if (want.packet_complete)
          completes++;
        expected_results.push_back(want);
      end
    end
    error_count    <= errs;
    outstanding    <= expected_results.size();
    result_count   <= results;
    eviction_count <= evicts;
    complete_count <= completes;
  end

endmodule

[sim/fragment_reassembly_tracker_tb.sv]
`timescale 1ns / 100ps

module fragment_reassembly_tracker_tb;
  import frt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 55;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AFTER  = 150;
  localparam int PLAN_LEN    = 6;

  typedef struct {
    logic [31:0] host;
    logic [15:0] port;
    logic [31:0] nonce;
    logic [6:0]  total;
  } packet_key_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  frt_in_t          in_data     = '0;
  logic             out_ready   = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_ready;
  logic             out_valid;
  frt_out_t         out_data;

  int error_count;
  int outstanding;
  int result_count;
  int eviction_count;
  int complete_count;

  int          sent_count     = 0;
  int          cycle_count    = 0;
  int          effective_size = 16;
  bit          long_hold_done = 1'b0;
  packet_key_t open_packets [$];
  int          cfg_plan [PLAN_LEN] = '{31, 1, 0, 5, 2, 16};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fragment_reassembly_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  fragment_reassembly_tracker_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .error_count   (error_count),
    .outstanding   (outstanding),
    .result_count  (result_count),
    .eviction_count(eviction_count),
    .complete_count(complete_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off while headers keep coming
  initial begin
    int r;
    int len;
    forever begin
      if (!long_hold_done && sent_count >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 8);
        end else if (r < 85) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_ready <= 1'b1;
          len = $urandom_range(20, 60);
        end else begin
          out_ready <= 1'b0;
          len = $urandom_range(10, 40);
        end
        // cut a random stretch short once the long hold-off is due
        repeat (len) begin
          @(posedge clk);
          if (!long_hold_done && sent_count >= HOLD_AFTER)
            break;
        end
      end
    end
  end

  // offer one header after a random gap and wait until it is taken
  task automatic send_chunk(input frt_in_t hdr);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 70)
      gap = 0;
    else if (r < 95)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= hdr;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // drain, let the pipeline settle, then change the table size
  task automatic set_table_size(input int value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_data <= value[CFG_W-1:0];
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    effective_size = (value == 0) ? 1 : ((value > 16) ? 16 : value);
  endtask

  function automatic frt_in_t chunk_of(packet_key_t k, logic [5:0] idx);
    frt_in_t h;
    h.sender_host = k.host;
    h.sender_port = k.port;
    h.msg_nonce   = k.nonce;
    h.chunk_total = k.total;
    h.chunk_index = idx;
    return h;
  endfunction

  // mostly small packets so they complete, a few up to the full count
  function automatic logic [6:0] pick_total();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      return 7'($urandom_range(1, 6));
    else if (r < 95)
      return 7'($urandom_range(7, 63));
    return 7'd64;
  endfunction

  // new packet key, sometimes a near copy of an open one
  function automatic packet_key_t fresh_packet();
    packet_key_t k;
    if (open_packets.size() > 0 && $urandom_range(0, 3) == 0) begin
      k = open_packets[$urandom_range(0, open_packets.size() - 1)];
      case ($urandom_range(0, 2))
        0:       k.nonce = $urandom;
        1:       k.port  = 16'($urandom);
        default: k.total = pick_total();
      endcase
    end else begin
      k.host  = $urandom;
      k.port  = 16'($urandom);
      k.nonce = $urandom;
      k.total = pick_total();
    end
    return k;
  endfunction

  // mostly chunks of open packets, the rest malformed or noise
  function automatic frt_in_t random_chunk();
    packet_key_t k;
    frt_in_t     h;
    int          r;
    int          pool_max;
    pool_max = (effective_size < 6) ? effective_size : 6;
    r = $urandom_range(0, 99);
    if (r < 10 || open_packets.size() == 0) begin
      k = fresh_packet();
      open_packets.push_back(k);
      if (open_packets.size() > pool_max)
        open_packets.delete($urandom_range(0, open_packets.size() - 2));
      return chunk_of(k, 6'($urandom_range(0, k.total - 1)));
    end
    k = open_packets[$urandom_range(0, open_packets.size() - 1)];
    if (r < 80 || (r < 86 && k.total == 64))
      return chunk_of(k, 6'($urandom_range(0, k.total - 1)));
    if (r < 86)
      return chunk_of(k, 6'($urandom_range(k.total, 63)));
    if (r < 90) begin
      k.total = 7'd0;
      return chunk_of(k, 6'($urandom));
    end
    h.sender_host = $urandom;
    h.sender_port = 16'($urandom);
    h.msg_nonce   = $urandom;
    h.chunk_total = (r < 95) ? 7'($urandom_range(65, 127)) : 7'($urandom_range(0, 127));
    h.chunk_index = 6'($urandom);
    return h;
  endfunction

  // stimulus and verdict
  initial begin
    packet_key_t burst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, duplicates, oversize counts, zero count,
    // index at or past the count, newest-match choice, near-miss keys
    send_chunk(frt_in_t'{32'h0, 16'h0, 32'h0, 7'd1, 6'd0});
    send_chunk(frt_in_t'{32'h0, 16'h0, 32'h0, 7'd1, 6'd0});
    send_chunk(frt_in_t'{32'hffffffff, 16'hffff, 32'hffffffff, 7'd64, 6'd63});
    send_chunk(frt_in_t'{32'hffffffff, 16'hffff, 32'hffffffff, 7'd64, 6'd0});
    send_chunk(frt_in_t'{32'hffffffff, 16'hffff, 32'hffffffff, 7'd64, 6'd63});
    send_chunk(frt_in_t'{32'hffffffff, 16'hffff, 32'hffffffff, 7'd65, 6'd0});
    send_chunk(frt_in_t'{32'hffffffff, 16'hffff, 32'hffffffff, 7'd127, 6'd63});
    send_chunk(frt_in_t'{32'h1, 16'h2, 32'h3, 7'd0, 6'd0});
    send_chunk(frt_in_t'{32'h1, 16'h2, 32'h3, 7'd0, 6'd0});
    send_chunk(frt_in_t'{32'ha5a5a5a5, 16'h5a5a, 32'h12345678, 7'd3, 6'd5});
    send_chunk(frt_in_t'{32'ha5a5a5a5, 16'h5a5a, 32'h12345678, 7'd3, 6'd3});
    send_chunk(frt_in_t'{32'ha5a5a5a5, 16'h5a5a, 32'h12345678, 7'd3, 6'd1});
    send_chunk(frt_in_t'{32'ha5a5a5a5, 16'h5a5a, 32'h12345678, 7'd3, 6'd0});
    send_chunk(frt_in_t'{32'ha5a5a5a5, 16'h5a5a, 32'h12345678, 7'd3, 6'd2});
    send_chunk(frt_in_t'{32'ha5a5a5a5, 16'h5a5a, 32'h12345678, 7'd2, 6'd1});
    send_chunk(frt_in_t'{32'ha5a5a5a5, 16'h5a5a, 32'h12345679, 7'd3, 6'd1});
    send_chunk(frt_in_t'{32'ha5a5a5a5, 16'h5a5b, 32'h12345678, 7'd3, 6'd1});
    send_chunk(frt_in_t'{32'ha5a5a5a4, 16'h5a5a, 32'h12345678, 7'd3, 6'd1});

    // random phases, one table size each
    for (int p = 0; p < PLAN_LEN; p++) begin
      set_table_size(cfg_plan[p]);
      if (cfg_plan[p] == 16) begin
        // one maximum-size packet sent whole
        burst.host  = $urandom;
        burst.port  = 16'($urandom);
        burst.nonce = $urandom;
        burst.total = 7'd64;
        for (int i = 0; i < 64; i++)
          send_chunk(chunk_of(burst, 6'(i)));
      end
      repeat (PHASE_ITEMS) send_chunk(random_chunk());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d chunk headers over %0d table sizes: %0d evictions, %0d packets complete",
             result_count, PLAN_LEN + 1, eviction_count, complete_count);
    $display("result side held off for %0d cycles once with headers still offered", LONG_HOLD);
    if (error_count == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/frt_pkg.sv
sv/frt_table.sv
sv/fragment_reassembly_tracker.sv
sim/fragment_reassembly_tracker_checker.sv
sim/fragment_reassembly_tracker_tb.sv
